// ===== design/paged_lcd_refresh_sequencer_assert.svh =====
// ----------------------------------------------------------------------------
// paged_lcd_refresh_sequencer_assert.svh
// assertion macros for the checker file
// ----------------------------------------------------------------------------
`ifndef PAGED_LCD_REFRESH_SEQUENCER_ASSERT_SVH
`define PAGED_LCD_REFRESH_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define PLRS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("plrs assertion failed");

// next-cycle implication
`define PLRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("plrs assertion failed");

`endif

// ===== design/plrs_pkg.sv =====
// ----------------------------------------------------------------------------
// plrs_pkg
// shared types, step codes and command bytes of the lcd refresh sequencer
// ----------------------------------------------------------------------------
package plrs_pkg;

    localparam int DEFAULT_PAGE_COUNT   = 8;
    localparam int DEFAULT_COLUMN_COUNT = 128;
    localparam int PAGE_BITS_MAX        = 4;

    // configuration register indexes
    localparam logic [1:0] CFG_IDX_CONTRAST = 2'd0;
    localparam logic [1:0] CFG_IDX_RATIO    = 2'd1;

    localparam logic [5:0] CONTRAST_RESET = 6'd17;
    localparam logic [2:0] RATIO_RESET    = 3'd6;

    // command bytes
    localparam logic [7:0] CMD_START_LINE = 8'h40;
    localparam logic [7:0] CMD_PAGE_BASE  = 8'hB0;
    localparam logic [7:0] CMD_COL_HIGH   = 8'h10;
    localparam logic [7:0] CMD_COL_LOW    = 8'h00;
    localparam logic [7:0] CMD_ADC_NORMAL = 8'hA0;
    localparam logic [7:0] CMD_DISP_OFF   = 8'hAE;
    localparam logic [7:0] CMD_COM_REV    = 8'hC8;
    localparam logic [7:0] CMD_BIAS       = 8'hA2;
    localparam logic [7:0] CMD_POWER      = 8'h2F;
    localparam logic [7:0] CMD_RATIO_BASE = 8'h20;
    localparam logic [7:0] CMD_VOLUME     = 8'h81;
    localparam logic [7:0] CMD_DISP_ON    = 8'hAF;

    typedef logic [3:0] step_t;

    localparam step_t S_START = 4'd0;
    localparam step_t S_PAGE  = 4'd1;
    localparam step_t S_COLHI = 4'd2;
    localparam step_t S_COLLO = 4'd3;
    localparam step_t S_DATA  = 4'd4;
    localparam step_t S_I0    = 4'd5;
    localparam step_t S_I1    = 4'd6;
    localparam step_t S_I2    = 4'd7;
    localparam step_t S_I3    = 4'd8;
    localparam step_t S_I4    = 4'd9;
    localparam step_t S_I5    = 4'd10;
    localparam step_t S_I6    = 4'd11;
    localparam step_t S_I7    = 4'd12;
    localparam step_t S_I8    = 4'd13;

    typedef struct packed {
        logic [PAGE_BITS_MAX-1:0] page;
        logic                     at_start;
        logic                     at_page;
    } pos_t;

    typedef struct packed {
        logic                     action;
        logic                     side;
        logic [7:0]               pixel;
        logic [PAGE_BITS_MAX-1:0] page;
        logic                     at_start;
        logic                     at_page;
    } item_t;

    function automatic step_t first_step(input item_t it);
        step_t s;
        if (it.action)
            s = S_I0;
        else if (it.at_start)
            s = S_START;
        else if (it.at_page)
            s = S_PAGE;
        else
            s = S_DATA;
        return s;
    endfunction

    function automatic step_t next_step(input step_t s, input logic at_page);
        step_t n;
        case (s)
            S_START: n = at_page ? S_PAGE : S_DATA;
            S_PAGE:  n = S_COLHI;
            S_COLHI: n = S_COLLO;
            S_COLLO: n = S_DATA;
            default: n = s + 4'd1;
        endcase
        return n;
    endfunction

endpackage

// ===== design/plrs_pos.sv =====
// ----------------------------------------------------------------------------
// plrs_pos
// frame position kept as page and column counters
// ----------------------------------------------------------------------------
module plrs_pos
    import plrs_pkg::*;
#(
    parameter int PAGE_COUNT   = DEFAULT_PAGE_COUNT,
    parameter int COLUMN_COUNT = DEFAULT_COLUMN_COUNT
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic advance,
    input  logic restart,
    output pos_t pos
);

    localparam int PAGE_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int COL_W  = (COLUMN_COUNT > 1) ? $clog2(COLUMN_COUNT) : 1;

    logic [PAGE_W-1:0] page_reg, page_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic              col_wrap;
    logic              page_wrap;

    assign col_wrap  = (col_reg == COL_W'(COLUMN_COUNT - 1));
    assign page_wrap = (page_reg == PAGE_W'(PAGE_COUNT - 1));

    always_comb
    begin
        page_next = page_reg;
        col_next  = col_reg;
        if (restart)
        begin
            page_next = '0;
            col_next  = '0;
        end
        else if (advance)
        begin
            if (col_wrap)
            begin
                col_next  = '0;
                page_next = page_wrap ? '0 : page_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_reg <= '0;
            col_reg  <= '0;
        end
        else
        begin
            page_reg <= page_next;
            col_reg  <= col_next;
        end
    end

    assign pos.page     = PAGE_BITS_MAX'(page_reg);
    assign pos.at_page  = (col_reg == '0);
    assign pos.at_start = (col_reg == '0) && (page_reg == '0);

endmodule

// ===== design/plrs_emit.sv =====
// ----------------------------------------------------------------------------
// plrs_emit
// item register, step sequencing and output register
// ----------------------------------------------------------------------------
module plrs_emit
    import plrs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  item_t      load_item,
    input  logic [5:0] contrast,
    input  logic [2:0] ratio,
    output logic       item_free,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic [1:0] m_tuser,
    output logic       m_tlast
);

    item_t      item_reg;
    step_t      step_reg;
    logic       item_valid_reg;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_data_reg;
    logic       out_side_reg;
    logic       out_last_reg;

    logic       out_free;
    logic       fire;
    logic       step_last;
    logic [7:0] byte_sel;

    assign out_free  = !out_valid_reg || m_tready;
    assign fire      = item_valid_reg && out_free;
    assign step_last = (step_reg == S_DATA) || (step_reg == S_I8);
    assign item_free = !item_valid_reg || (fire && step_last);

    always_comb
    begin
        unique case (step_reg)
            S_START: byte_sel = CMD_START_LINE;
            S_PAGE:  byte_sel = CMD_PAGE_BASE + 8'(item_reg.page);
            S_COLHI: byte_sel = CMD_COL_HIGH;
            S_COLLO: byte_sel = CMD_COL_LOW;
            S_DATA:  byte_sel = item_reg.pixel;
            S_I0:    byte_sel = CMD_ADC_NORMAL;
            S_I1:    byte_sel = CMD_DISP_OFF;
            S_I2:    byte_sel = CMD_COM_REV;
            S_I3:    byte_sel = CMD_BIAS;
            S_I4:    byte_sel = CMD_POWER;
            S_I5:    byte_sel = CMD_RATIO_BASE | {5'd0, ratio};
            S_I6:    byte_sel = CMD_VOLUME;
            S_I7:    byte_sel = {2'b00, contrast};
            S_I8:    byte_sel = CMD_DISP_ON;
            default: byte_sel = CMD_DISP_ON;
        endcase
    end

    // item register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            step_reg       <= S_DATA;
        end
        else if (load)
        begin
            item_valid_reg <= 1'b1;
            step_reg       <= first_step(load_item);
        end
        else if (fire && step_last)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            step_reg <= next_step(step_reg, item_reg.at_page);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= load_item;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_byte_reg <= byte_sel;
            out_data_reg <= (step_reg == S_DATA);
            out_side_reg <= item_reg.side;
            out_last_reg <= step_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = {out_side_reg, out_data_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ===== design/paged_lcd_refresh_sequencer.sv =====
// ----------------------------------------------------------------------------
// paged_lcd_refresh_sequencer
// turns frame bytes and init requests into command and data bytes for a
// two-chip paged monochrome lcd controller
// ----------------------------------------------------------------------------
// channel   dir  handshake            payload
// s_*       in   s_tvalid / s_tready  tdata = pixel_byte, tuser = action, side
// m_*       out  m_tvalid / m_tready  tdata = out_byte, tuser = is_data,
//                                     chip_side, tlast = last
// cfg_*     in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one result leaves per cycle while the output is not stalled; a pixel item
// yields 1 to 5 results, an init item 9, and the item holds the input until done.
// the first result passes the item register, then the output register,
// before it is on m_*.
// reset clears the frame position and loads contrast 17, resistor ratio 6.
// a stalled output holds its result; the input is taken again as soon as the
// last result of the current item moves into the output register.
// ----------------------------------------------------------------------------
module paged_lcd_refresh_sequencer
    import plrs_pkg::*;
#(
    parameter int PAGE_COUNT   = DEFAULT_PAGE_COUNT,
    parameter int COLUMN_COUNT = DEFAULT_COLUMN_COUNT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] pixel_byte
    input  logic [1:0] s_tuser,    // [0] action, [1] side
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] out_byte
    output logic [1:0] m_tuser,    // [0] is_data, [1] chip_side
    output logic       m_tlast,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [5:0] cfg_data
);

    logic [5:0] contrast_reg;
    logic [2:0] ratio_reg;
    logic       accept;
    logic       item_free;
    pos_t       pos;
    item_t      new_item;

    assign cfg_ready = 1'b1;
    assign s_tready  = item_free;
    assign accept    = s_tvalid && item_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            contrast_reg <= CONTRAST_RESET;
            ratio_reg    <= RATIO_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_IDX_CONTRAST: contrast_reg <= cfg_data;
                CFG_IDX_RATIO:    ratio_reg    <= cfg_data[2:0];
                default:          ;
            endcase
        end
    end

    plrs_pos #(
        .PAGE_COUNT   (PAGE_COUNT),
        .COLUMN_COUNT (COLUMN_COUNT)
    ) u_pos (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (accept && !s_tuser[0]),
        .restart (accept && s_tuser[0]),
        .pos     (pos)
    );

    assign new_item.action   = s_tuser[0];
    assign new_item.side     = s_tuser[1];
    assign new_item.pixel    = s_tdata;
    assign new_item.page     = pos.page;
    assign new_item.at_start = pos.at_start;
    assign new_item.at_page  = pos.at_page;

    plrs_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .load_item (new_item),
        .contrast  (contrast_reg),
        .ratio     (ratio_reg),
        .item_free (item_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== design/plrs_checker.sv =====
// ----------------------------------------------------------------------------
// plrs_checker
// port-level checks of the lcd refresh sequencer
// ----------------------------------------------------------------------------
`include "paged_lcd_refresh_sequencer_assert.svh"

module plrs_checker
    import plrs_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser,
    input logic       m_tlast
);

    // stalled output item holds
    `PLRS_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // a data byte always ends its item
    `PLRS_ASSERT_NOW(a_data_last, clk, rst_n, m_tvalid && m_tuser[0], m_tlast)

    // a command that ends an item is display on
    `PLRS_ASSERT_NOW(a_cmd_last, clk, rst_n, m_tvalid && m_tlast && !m_tuser[0],
        m_tdata == CMD_DISP_ON)

    // start line is always followed by more of the same item
    `PLRS_ASSERT_NOW(a_start_not_last, clk, rst_n,
        m_tvalid && !m_tuser[0] && (m_tdata == CMD_START_LINE), !m_tlast)

endmodule

bind paged_lcd_refresh_sequencer plrs_checker u_plrs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
